// ===== rtl/sm3_hash_engine_assert.svh =====
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Shared concurrent assertion wrappers, all clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

// Checked only while out of reset.
`define SM3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SM3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 package
// Constants, types and helper functions shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sm3_pkg;

  // Initial chaining value.
  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h000000};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_EXTRA,
    ST_PAD_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_COMPRESS,
    ST_FINISH,
    ST_OUTPUT
  } sm3_state_e;

  // Source of a word written into the block window.
  typedef enum logic [2:0] {
    SEL_INPUT,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } sm3_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;    // input transfer, update the bit length
    logic     push;      // write one word into the block window
    sm3_sel_e push_sel;
    logic     round_en;  // run one compression round
    logic     finish;    // fold round registers into the chaining value
    logic     out_adv;   // digest word transferred
    logic     clear;     // rearm for a new message
  } sm3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_last;   // next push completes a block
    logic slot_is_14;  // room left only for the length words
    logic round_last;  // current round is the 64th
    logic in_final;
    logic in_vb_full;
    logic out_last;    // digest index is seven
  } sm3_status_t;

  // Rotate left by a variable amount.
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Round constant, rotated by the round number modulo 32.
  function automatic logic [31:0] t_rot(input logic [5:0] j);
    logic [31:0] t;
    t = (j < 6'd16) ? T_LOW : T_HIGH;
    return rotl(t, j[4:0]);
  endfunction

endpackage

// ===== rtl/sm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences input transfers, padding, compression and digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm3_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sm3_pkg::sm3_status_t status_i,
  output sm3_pkg::sm3_cmd_t    cmd_o
);

  sm3_pkg::sm3_state_e state_q, state_d;
  sm3_pkg::sm3_state_e ret_q, ret_d;
  sm3_pkg::sm3_state_e push_next;

  // State and return-state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sm3_pkg::ST_IDLE;
      ret_q   <= sm3_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    push_next       = sm3_pkg::ST_IDLE;
    cmd_o           = '0;
    cmd_o.push_sel  = sm3_pkg::SEL_ZERO;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;

    unique case (state_q)
      sm3_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept   = 1'b1;
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = sm3_pkg::SEL_INPUT;
          if (!status_i.in_final) begin
            push_next = sm3_pkg::ST_IDLE;
          end else if (status_i.in_vb_full) begin
            push_next = sm3_pkg::ST_PAD_EXTRA;
          end else begin
            push_next = sm3_pkg::ST_PAD_ZERO;
          end
        end
      end
      sm3_pkg::ST_PAD_EXTRA: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = sm3_pkg::SEL_PAD;
        push_next      = sm3_pkg::ST_PAD_ZERO;
      end
      sm3_pkg::ST_PAD_ZERO: begin
        if (status_i.slot_is_14) begin
          state_d = sm3_pkg::ST_LEN_HI;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = sm3_pkg::SEL_ZERO;
          push_next      = sm3_pkg::ST_PAD_ZERO;
        end
      end
      sm3_pkg::ST_LEN_HI: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = sm3_pkg::SEL_LEN_HI;
        push_next      = sm3_pkg::ST_LEN_LO;
      end
      sm3_pkg::ST_LEN_LO: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = sm3_pkg::SEL_LEN_LO;
        push_next      = sm3_pkg::ST_OUTPUT;
      end
      sm3_pkg::ST_COMPRESS: begin
        cmd_o.round_en = 1'b1;
        if (status_i.round_last) begin
          state_d = sm3_pkg::ST_FINISH;
        end
      end
      sm3_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ret_q;
      end
      sm3_pkg::ST_OUTPUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_adv = 1'b1;
          if (status_i.out_last) begin
            cmd_o.clear = 1'b1;
            state_d     = sm3_pkg::ST_IDLE;
          end
        end
      end
    endcase

    // A push that completes the block detours through compression.
    if (cmd_o.push) begin
      if (status_i.slot_last) begin
        state_d = sm3_pkg::ST_COMPRESS;
        ret_d   = push_next;
      end else begin
        state_d = push_next;
      end
    end
  end

endmodule

// ===== rtl/sm3_datapath.sv =====
// ----------------------------------------------------------------------------
// SM3 datapath
// Block window with message expansion, round registers, chaining value,
// bit length and output word selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm3_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          msg_word_i,
  input  logic [2:0]           valid_bytes_i,
  input  logic                 final_word_i,
  input  sm3_pkg::sm3_cmd_t    cmd_i,
  output sm3_pkg::sm3_status_t status_o,
  output logic [31:0]          digest_word_o,
  output logic [2:0]           digest_index_o,
  output logic                 digest_done_o
);

  logic [31:0] win_q   [16];
  logic [31:0] rr_q    [8];
  logic [31:0] chain_q [8];
  logic [63:0] len_q;
  logic [3:0]  slot_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;

  logic [2:0]  vb_sat;
  logic [31:0] in_word;
  logic [31:0] push_word;
  logic [31:0] new_w;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [63:0] len_add;

  // Byte count saturates at four.
  assign vb_sat = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;

  // Input word, with the pad byte placed after a partial final word.
  always_comb begin
    if (!final_word_i) begin
      in_word = msg_word_i;
    end else begin
      case (vb_sat)
        3'd0:    in_word = sm3_pkg::PAD_WORD;
        3'd1:    in_word = {msg_word_i[31:24], sm3_pkg::PAD_BYTE, 16'h0000};
        3'd2:    in_word = {msg_word_i[31:16], sm3_pkg::PAD_BYTE, 8'h00};
        3'd3:    in_word = {msg_word_i[31:8], sm3_pkg::PAD_BYTE};
        default: in_word = msg_word_i;
      endcase
    end
  end

  // Word source for the block window.
  always_comb begin
    unique case (cmd_i.push_sel)
      sm3_pkg::SEL_INPUT:  push_word = in_word;
      sm3_pkg::SEL_PAD:    push_word = sm3_pkg::PAD_WORD;
      sm3_pkg::SEL_LEN_HI: push_word = len_q[63:32];
      sm3_pkg::SEL_LEN_LO: push_word = len_q[31:0];
      default:             push_word = 32'h0;
    endcase
  end

  // One compression round and the next expanded message word.
  always_comb begin
    a12 = sm3_pkg::rotl(rr_q[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + rr_q[4] + sm3_pkg::t_rot(rnd_q), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = rr_q[0] ^ rr_q[1] ^ rr_q[2];
      gg = rr_q[4] ^ rr_q[5] ^ rr_q[6];
    end else begin
      ff = (rr_q[0] & rr_q[1]) | (rr_q[0] & rr_q[2]) | (rr_q[1] & rr_q[2]);
      gg = (rr_q[4] & rr_q[5]) | (~rr_q[4] & rr_q[6]);
    end
    tt1   = ff + rr_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2   = gg + rr_q[7] + ss1 + win_q[0];
    new_w = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl(win_q[13], 5'd15))
            ^ sm3_pkg::rotl(win_q[3], 5'd7) ^ win_q[10];
  end

  // Block window: pushes and rounds both shift toward entry zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= cmd_i.push ? push_word : new_w;
    end
  end

  // Round registers, loaded from the chaining value as a block completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && status_o.slot_last) begin
      for (int i = 0; i < 8; i++) begin
        rr_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round_en) begin
      rr_q[0] <= tt1;
      rr_q[1] <= rr_q[0];
      rr_q[2] <= sm3_pkg::rotl(rr_q[1], 5'd9);
      rr_q[3] <= rr_q[2];
      rr_q[4] <= sm3_pkg::perm0(tt2);
      rr_q[5] <= rr_q[4];
      rr_q[6] <= sm3_pkg::rotl(rr_q[5], 5'd19);
      rr_q[7] <= rr_q[6];
    end
  end

  // Bit length added by an input transfer.
  assign len_add = final_word_i ? {58'd0, vb_sat, 3'b000} : 64'd32;

  // Chaining value, length and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sm3_pkg::IV[i];
      end
      len_q  <= '0;
      slot_q <= '0;
      rnd_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= sm3_pkg::IV[i];
        end
      end else if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] ^ rr_q[i];
        end
      end
      if (cmd_i.clear) begin
        len_q <= '0;
      end else if (cmd_i.accept) begin
        len_q <= len_q + len_add;
      end
      if (cmd_i.clear) begin
        slot_q <= '0;
      end else if (cmd_i.push) begin
        slot_q <= slot_q + 4'd1;
      end
      if (cmd_i.push && status_o.slot_last) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.out_adv) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.slot_last  = (slot_q == 4'd15);
    status_o.slot_is_14 = (slot_q == 4'd14);
    status_o.round_last = (rnd_q == 6'd63);
    status_o.in_final   = final_word_i;
    status_o.in_vb_full = (valid_bytes_i >= 3'd4);
    status_o.out_last   = (idx_q == 3'd7);
  end

  // Digest output.
  assign digest_word_o  = chain_q[idx_q];
  assign digest_index_o = idx_q;
  assign digest_done_o  = (idx_q == 3'd7);

endmodule

// ===== rtl/sm3_hash_engine.sv =====
// Each full block runs 64 compression rounds, one per cycle in the round
// datapath, and then one chaining update. A final word adds padding pushes,
// one or two compressions and eight digest transfers.
// Reset is asynchronous, active low: chaining value to the initial vector,
// length and counters to zero, no clearing pass.
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams message words, pads the final block and returns the 256-bit digest
// as eight 32-bit words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sm3_hash_engine_assert.svh"

module sm3_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_done_o
);

  sm3_pkg::sm3_cmd_t    cmd;
  sm3_pkg::sm3_status_t status;

  // Controller.
  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  sm3_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_word_i     (msg_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .final_word_i   (final_word_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .digest_word_o  (digest_word_o),
    .digest_index_o (digest_index_o),
    .digest_done_o  (digest_done_o)
  );

  // Input and output sides are never open together.
  `SM3_ASSERT_ALWAYS(a_in_out_excl, !(in_ready_o && out_valid_o), "input and output both open")
  // After the last digest word the engine is ready for a new message.
  `SM3_ASSERT(a_rearm, (out_valid_o && out_ready_i && digest_done_o) |=> in_ready_o, "no rearm")
  // A window push and a compression round never share a cycle.
  `SM3_ASSERT(a_push_round, !(cmd.push && cmd.round_en), "push during round")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams whole messages into the engine and checks every digest word it
// returns against a hash computed alongside in this file. A queue of
// pending words, filled up front, feeds a clocked driver. A clocked monitor
// takes the digest words and compares them in order. Both sides idle in
// random bursts. The receiver also holds off once for a long stretch, and the
// sender waits at times for all digests to drain.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 440;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int TAIL_ITEMS   = 48;
  localparam int DRAIN_CYCLES = 100;

  // One input word of a message, plus a flag that makes the sender wait for
  // all outstanding digests before offering it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        drain_first;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        done;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] msg_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        final_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_done;

  msg_item_t    pending_words[$];
  digest_item_t digest_expected[$];
  msg_item_t    cur_item;
  int           error_count = 0;
  int           digests_seen = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  int           recv_hold = 0;
  int           idle_cycles = 0;
  logic         tail_phase = 1'b0;

  // Running hash state of the message being absorbed.
  logic [31:0] sm3_chain [8];
  logic [31:0] sm3_block [16];
  int          block_fill;
  logic [63:0] msg_bits;

  sm3_hash_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .msg_word_i    (msg_word),
    .valid_bytes_i (valid_bytes),
    .final_word_i  (final_word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .digest_word_o (digest_word),
    .digest_index_o(digest_index),
    .digest_done_o (digest_done)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Hash computation
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    int s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic sm3_restart();
    for (int k = 0; k < 8; k++) sm3_chain[k] = sm3_pkg::IV[k];
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Message expansion, 64 rounds and the feed-forward into the chain.
  task automatic sm3_compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] x, a12, ss1, ss2, ff, gg, tt1, tt2, t;
    for (int j = 0; j < 16; j++) w[j] = sm3_block[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
      w[j] = x ^ rol32(x, 15) ^ rol32(x, 23) ^ rol32(w[j-13], 7) ^ w[j-6];
    end
    a = sm3_chain[0]; b = sm3_chain[1]; c = sm3_chain[2]; d = sm3_chain[3];
    e = sm3_chain[4]; f = sm3_chain[5]; g = sm3_chain[6]; h = sm3_chain[7];
    for (int j = 0; j < 64; j++) begin
      t   = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = rol32(a, 12);
      ss1 = rol32(a12 + e + rol32(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol32(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol32(f, 19);
      f = e;
      e = tt2 ^ rol32(tt2, 9) ^ rol32(tt2, 17);
    end
    sm3_chain[0] ^= a; sm3_chain[1] ^= b; sm3_chain[2] ^= c; sm3_chain[3] ^= d;
    sm3_chain[4] ^= e; sm3_chain[5] ^= f; sm3_chain[6] ^= g; sm3_chain[7] ^= h;
  endtask

  task automatic sm3_push(input logic [31:0] wd);
    sm3_block[block_fill] = wd;
    block_fill++;
    if (block_fill == 16) begin
      sm3_compress();
      block_fill = 0;
    end
  endtask

  // Absorbs one transferred word; a final word pads, closes the message and
  // queues the eight digest words it must produce.
  task automatic sm3_absorb_item(input msg_item_t it);
    int           nb;
    logic [31:0]  keep;
    digest_item_t dw;
    nb = (it.nbytes > 3'd4) ? 4 : int'(it.nbytes);
    if (!it.last) begin
      msg_bits += 64'd32;
      sm3_push(it.word);
    end else begin
      msg_bits += 64'(8 * nb);
      if (nb == 4) begin
        sm3_push(it.word);
        sm3_push({sm3_pkg::PAD_BYTE, 24'h000000});
      end else begin
        keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
        sm3_push((it.word & keep) | ({24'h0, sm3_pkg::PAD_BYTE} << (24 - 8 * nb)));
      end
      // No room for the length words: close this block with zeros first.
      if (block_fill == 15) sm3_push(32'h0);
      while (block_fill < 14) sm3_push(32'h0);
      sm3_push(msg_bits[63:32]);
      sm3_push(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        dw.word  = sm3_chain[k];
        dw.index = k[2:0];
        dw.done  = (k == 7);
        digest_expected.push_back(dw);
      end
      sm3_restart();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(input logic [31:0] wd, input logic [2:0] nb, input logic last,
                          input logic drain);
    msg_item_t it;
    it.word = wd;
    it.nbytes = nb;
    it.last = last;
    it.drain_first = drain;
    pending_words.push_back(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending words, with random gaps outside the tail.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic      nxt_valid;
    logic      sent;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      msg_word    <= '0;
      valid_bytes <= '0;
      final_word  <= 1'b0;
      tail_phase  <= 1'b0;
      send_gap    = 0;
    end else begin
      sent = in_valid && in_ready;
      if (sent) sm3_absorb_item(cur_item);
      if (sent || !in_valid) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() == 0) begin
          nxt_valid = 1'b0;
        end else if (pending_words[0].drain_first && digest_expected.size() != 0) begin
          nxt_valid = 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
        end else begin
          cur_item = pending_words.pop_front();
          nxt_valid = 1'b1;
          msg_word    <= cur_item.word;
          valid_bytes <= cur_item.nbytes;
          final_word  <= cur_item.last;
        end
        in_valid <= nxt_valid;
      end
      tail_phase <= (pending_words.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each digest transfer and drives the ready side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    digest_item_t want;
    logic         nxt_ready;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
      recv_hold  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_expected.size() == 0) begin
          report_error($sformatf("digest word %h index %0d with no digest pending",
                                 digest_word, digest_index));
        end else begin
          want = digest_expected.pop_front();
          if (digest_word !== want.word)
            report_error($sformatf("digest word %0d: got %h, expected %h",
                                   want.index, digest_word, want.word));
          if (digest_index !== want.index)
            report_error($sformatf("digest index: got %0d, expected %0d",
                                   digest_index, want.index));
          if (digest_done !== want.done)
            report_error($sformatf("digest done at index %0d: got %b, expected %b",
                                   want.index, digest_done, want.done));
        end
        digests_seen++;
        // One long hold-off so that the engine backs up into its input.
        if (digests_seen == HOLD_AFTER) recv_hold = HOLD_CYCLES;
      end
      nxt_ready = 1'b1;
      if (recv_hold > 0) begin
        recv_hold--;
        nxt_ready = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(1, 16) - 1;
        nxt_ready = 1'b0;
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** sm3_hash_engine: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Message list, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int    random_count;
    int    nwords;
    logic  drain;
    logic  mid_drain_done;
    logic  first_random;

    sm3_restart();

    // Empty message; the offered bits must be dropped.
    add_item(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
    // Three bytes with a stray low byte that must be masked.
    add_item(32'h6162_63FF, 3'd3, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
    add_item(32'h0000_0000, 3'd4, 1'b1, 1'b0);
    // Byte counts above four act as four.
    add_item(32'h1234_5678, 3'd5, 1'b1, 1'b0);
    add_item(32'h9ABC_DEF0, 3'd6, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0);
    add_item(32'hA5A5_A5A5, 3'd2, 1'b1, 1'b0);
    // Fourteen plain words and a full final word: the padding spills into
    // a second block. Byte counts on the plain words are ignored.
    for (int i = 0; i < 14; i++)
      add_item((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(i % 8), 1'b0, 1'b0);
    add_item(32'h8000_0001, 3'd4, 1'b1, 1'b0);

    // Random messages, mostly short, a few spanning several blocks.
    random_count   = 0;
    mid_drain_done = 1'b0;
    first_random   = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
      drain = first_random || (!mid_drain_done && random_count >= RANDOM_ITEMS / 2);
      if (drain && !first_random) mid_drain_done = 1'b1;
      first_random = 1'b0;
      for (int i = 0; i < nwords; i++)
        add_item(rand_word(), 3'($urandom_range(0, 7)), 1'b0, drain && (i == 0));
      add_item(rand_word(), 3'($urandom_range(0, 7)), 1'b1, drain && (nwords == 0));
      random_count += nwords + 1;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (pending_words.size() != 0 || in_valid || digest_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** sm3_hash_engine: PASSED **");
    end else begin
      $display("** sm3_hash_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sm3_pkg.sv
rtl/sm3_ctrl.sv
rtl/sm3_datapath.sv
rtl/sm3_hash_engine.sv
tb/testbench.sv
